// ===== rtl/tile_code_run_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// tile code run decoder assertion macros
// shared concurrent assertion forms on clk_i, disabled during reset
// ----------------------------------------------------------------------------
`ifndef TILE_CODE_RUN_DECODER_MACROS_SVH
`define TILE_CODE_RUN_DECODER_MACROS_SVH

// property that holds at every clock edge out of reset
`define TCRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that implies a consequence in the same cycle
`define TCRD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition that implies a consequence in the next cycle
`define TCRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcrd_pkg.sv =====
// ----------------------------------------------------------------------------
// tcrd_pkg
// types, codes and helpers shared by the tile code run decoder
// ----------------------------------------------------------------------------
package tcrd_pkg;

  localparam int unsigned TILE_TEXELS_DEF = 1024;

  localparam int unsigned BYTES_W   = 13;
  localparam logic [BYTES_W-1:0] BYTES_MAX = 13'h1fff;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ENC_PACKED  = 2'd0,
    ENC_RLE     = 2'd1,
    ENC_CONST   = 2'd2,
    ENC_INVALID = 2'd3
  } enc_e;

  typedef struct packed {
    logic [9:0]  start;
    logic [10:0] length;
    logic [7:0]  runoff;
    logic [7:0]  capacity;
    logic [7:0]  flow;
    logic        err;
    logic        tend;
  } run_t;

  // nibble times 17 is the nibble repeated in both halves
  function automatic logic [7:0] level17(input logic [3:0] nib);
    return {nib, nib};
  endfunction

  function automatic run_t make_run(input logic [9:0]  start,
                                    input logic [10:0] length,
                                    input logic [3:0]  runoff,
                                    input logic [7:0]  cf);
    run_t r;
    r.start    = start;
    r.length   = length;
    r.runoff   = level17(runoff);
    r.capacity = level17(cf[7:4]);
    r.flow     = level17(cf[3:0]);
    r.err      = 1'b0;
    r.tend     = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/tcrd_out_queue.sv =====
// ----------------------------------------------------------------------------
// tcrd_out_queue
// small result queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
module tcrd_out_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  tcrd_pkg::run_t data0_i,
  input  tcrd_pkg::run_t data1_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tcrd_pkg::run_t out_data_o
);
  import tcrd_pkg::*;

  run_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   cnt_q, cnt_d;
  logic           pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (cnt_q <= (QAW+1)'(QDEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + QAW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + QAW'(pop);
    cnt_d    = cnt_q + (QAW+1)'(push_cnt_i) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + QAW'(1)] <= data1_i;
    end
  end

endmodule

// ===== rtl/tile_code_run_decoder.sv =====
// ----------------------------------------------------------------------------
// tile_code_run_decoder
// decodes tile payload bytes into texel runs with scaled nibble levels
// ----------------------------------------------------------------------------
// input channel: in_valid_i/in_ready_o, one payload byte per transfer with
//   its encoding, first and last marks
// output channel: out_valid_o/out_ready_i, one run per transfer; a byte
//   gives zero, one or two runs, a malformed tile one error run at its end
// path: a byte is captured in the input register, then decoded into the
//   tile state and the result queue, from which its runs transfer
// throughput: one byte per cycle while not stalled, one run per cycle while
//   out_ready_i is high; the four-entry result queue absorbs the two runs
//   of a packed group
// stall: when the queue holds more than two runs the input register holds
//   its byte and in_ready_o drops; nothing is lost or repeated
// reset: tile state returns to an empty packed tile, the input register and
//   queue empty; held bytes are not cleared and are always written first
// ----------------------------------------------------------------------------
module tile_code_run_decoder #(
  parameter int unsigned TILE_TEXELS = tcrd_pkg::TILE_TEXELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] payload_byte_i,
  input  logic [1:0] encoding_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [9:0] run_start_o,
  output logic [10:0] run_length_o,
  output logic [7:0] runoff_level_o,
  output logic [7:0] capacity_level_o,
  output logic [7:0] flow_level_o,
  output logic       error_o,
  output logic       tile_end_o
);
  import tcrd_pkg::*;
  `include "tile_code_run_decoder_macros.svh"

  localparam int unsigned TW = $clog2(TILE_TEXELS + 1);
  localparam int unsigned SW = ((TW > 16) ? TW : 16) + 1;
  localparam logic [TW-1:0] TOTAL = TW'(TILE_TEXELS);

  // input register
  logic       in_v_q;
  logic [7:0] byte_q;
  enc_e       enc_q;
  logic       first_q, last_q;

  // tile state
  enc_e             mode_q, mode_d;
  logic [1:0]       phase_q, phase_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [TW-1:0]    tex_q, tex_d;
  logic             failed_q, failed_d;
  logic [7:0]       held_q [3];
  logic [7:0]       held_d [3];

  // decode temporaries
  enc_e               mode_e;
  logic [1:0]         phase_e, phase_n;
  logic [BYTES_W-1:0] bytes_e, bytes_n;
  logic [TW-1:0]      tex_e, tex_n;
  logic               fail_e;
  logic [15:0]        count;
  logic               ok;

  run_t       run0, run1;
  logic [1:0] n_runs, push_cnt;
  logic       room, adv;
  run_t       out_run;

  assign adv        = in_v_q && room;
  assign in_ready_o = !in_v_q || adv;
  assign push_cnt   = adv ? n_runs : 2'd0;
  assign count      = {held_q[1], held_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_v_q <= 1'b1;
    end else if (adv) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= payload_byte_i;
      enc_q   <= enc_e'(encoding_i);
      first_q <= first_byte_i;
      last_q  <= last_byte_i;
    end
  end

  always_comb begin
    mode_e  = mode_q;
    phase_e = phase_q;
    bytes_e = bytes_q;
    tex_e   = tex_q;
    fail_e  = failed_q;
    held_d  = held_q;
    run0    = '0;
    run1    = '0;
    n_runs  = 2'd0;
    ok      = 1'b0;

    if (first_q) begin
      mode_e  = enc_q;
      phase_e = 2'd0;
      bytes_e = '0;
      tex_e   = '0;
      fail_e  = (enc_q == ENC_INVALID);
    end
    bytes_n = (bytes_e < BYTES_MAX) ? bytes_e + BYTES_W'(1) : bytes_e;
    phase_n = phase_e;
    tex_n   = tex_e;

    case (mode_e)
      ENC_PACKED: begin
        if (phase_e < 2'd2) begin
          held_d[phase_e] = byte_q;
          phase_n = phase_e + 2'd1;
        end else begin
          phase_n = 2'd0;
          if (!fail_e && (SW'(tex_e) + SW'(2) > SW'(TILE_TEXELS))) begin
            fail_e = 1'b1;
          end
          if (!fail_e) begin
            run0   = make_run(10'(tex_e), 11'd1, byte_q[7:4], held_q[0]);
            run1   = make_run(10'(tex_e + TW'(1)), 11'd1, byte_q[3:0], held_q[1]);
            n_runs = 2'd2;
            tex_n  = tex_e + TW'(2);
          end
        end
      end
      ENC_RLE: begin
        if (phase_e < 2'd3) begin
          held_d[phase_e] = byte_q;
          phase_n = phase_e + 2'd1;
        end else begin
          phase_n = 2'd0;
          if (!fail_e && ((count == 16'd0) ||
                          (SW'(tex_e) + SW'(count) > SW'(TILE_TEXELS)))) begin
            fail_e = 1'b1;
          end
          if (!fail_e) begin
            run0   = make_run(10'(tex_e), 11'(count), byte_q[3:0], held_q[2]);
            n_runs = 2'd1;
            tex_n  = tex_e + TW'(count);
          end
        end
      end
      ENC_CONST: begin
        if (bytes_n == BYTES_W'(1)) begin
          held_d[0] = byte_q;
        end else if (bytes_n != BYTES_W'(2)) begin
          fail_e = 1'b1;
        end
      end
      default: begin
        fail_e = 1'b1;
      end
    endcase

    mode_d   = mode_e;
    phase_d  = phase_n;
    bytes_d  = bytes_n;
    tex_d    = tex_n;
    failed_d = fail_e;

    if (last_q) begin
      if (mode_e == ENC_CONST) begin
        ok = !fail_e && (bytes_n == BYTES_W'(2));
        if (ok) begin
          run0   = make_run(10'd0, 11'(TILE_TEXELS), byte_q[3:0], held_q[0]);
          n_runs = 2'd1;
        end
      end else begin
        ok = !fail_e && (phase_n == 2'd0) && (tex_n == TOTAL) && (n_runs != 2'd0);
      end
      if (ok) begin
        if (n_runs == 2'd2) begin
          run1.tend = 1'b1;
        end else begin
          run0.tend = 1'b1;
        end
      end else begin
        run0      = '0;
        run0.err  = 1'b1;
        run0.tend = 1'b1;
        n_runs    = 2'd1;
      end
      mode_d   = ENC_PACKED;
      phase_d  = 2'd0;
      bytes_d  = '0;
      tex_d    = '0;
      failed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ENC_PACKED;
      phase_q  <= 2'd0;
      bytes_q  <= '0;
      tex_q    <= '0;
      failed_q <= 1'b0;
    end else if (adv) begin
      mode_q   <= mode_d;
      phase_q  <= phase_d;
      bytes_q  <= bytes_d;
      tex_q    <= tex_d;
      failed_q <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      held_q <= held_d;
    end
  end

  tcrd_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .data0_i     (run0),
    .data1_i     (run1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_run)
  );

  assign run_start_o      = out_run.start;
  assign run_length_o     = out_run.length;
  assign runoff_level_o   = out_run.runoff;
  assign capacity_level_o = out_run.capacity;
  assign flow_level_o     = out_run.flow;
  assign error_o          = out_run.err;
  assign tile_end_o       = out_run.tend;

  `TCRD_ASSERT(a_tex_bound, tex_q <= TOTAL, "texel count past tile size")
  `TCRD_ASSERT_IMPLY(a_err_run, out_valid_o && error_o,
    tile_end_o && (run_length_o == 11'd0), "error run not a bare tile end")
  `TCRD_ASSERT_IMPLY(a_packed_phase, mode_q == ENC_PACKED, phase_q != 2'd3,
    "packed phase out of range")
  `TCRD_ASSERT_NEXT(a_tile_clear, adv && last_q,
    (bytes_q == '0) && (tex_q == '0) && !failed_q, "tile state not cleared")

endmodule
